### rtl/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// Shared types and constants for the integer literal parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

  // accumulator width; the value field itself is always 64 bits
  localparam int VALUE_W = 64;

  // classification queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEP   = 8'h27;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_LL    = 8'h6c;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] HEX_OFS  = 8'h57;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_BIN = 2'd1,
    RX_OCT = 2'd2,
    RX_HEX = 2'd3
  } ilp_radix_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_LEAD  = 2'd1,
    ERR_TRAIL = 2'd2,
    ERR_BAD   = 2'd3
  } ilp_err_t;

  typedef enum logic [1:0] {
    LK_NONE = 2'd0,
    LK_L    = 2'd1,
    LK_LL   = 2'd2
  } ilp_long_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ilp_in_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  radix;
    logic        is_unsigned;
    logic [1:0]  long_kind;
    logic        is_size;
    logic        overflowed;
    logic [1:0]  error_code;
  } ilp_out_t;

  // classified character, front to back
  typedef struct packed {
    logic [3:0] dval;   // digit value 0..15
    logic       dok;    // character is a digit 0-9, a-f or A-F
    logic       sep;
    logic       is_b;
    logic       is_x;
    logic       is_u;
    logic       is_l;
    logic       is_z;
    logic       last;
  } ilp_cls_t;

endpackage

### rtl/ilp_front.sv
// ----------------------------------------------------------------------------
// ilp_front
// Character classifier: digit value, separator and suffix letter flags.
// ----------------------------------------------------------------------------
module ilp_front (
  input  ilp_pkg::ilp_in_t  in_item,
  output ilp_pkg::ilp_cls_t cls
);
  import ilp_pkg::*;

  logic [7:0] lc;
  logic       is_dec;
  logic       is_af;

  always_comb begin
    lc     = in_item.ch | CASE_BIT;
    is_dec = (in_item.ch >= CH_ZERO) && (in_item.ch <= CH_NINE);
    is_af  = (lc >= CH_LA) && (lc <= CH_LF);

    cls.dok  = is_dec || is_af;
    if (is_dec) begin
      cls.dval = 4'(in_item.ch - CH_ZERO);
    end else begin
      cls.dval = 4'(lc - HEX_OFS);
    end
    cls.sep  = (in_item.ch == CH_SEP);
    cls.is_b = (lc == CH_LB);
    cls.is_x = (lc == CH_LX);
    cls.is_u = (lc == CH_LU);
    cls.is_l = (lc == CH_LL);
    cls.is_z = (lc == CH_LZ);
    cls.last = in_item.last;
  end

endmodule

### rtl/ilp_queue.sv
// ----------------------------------------------------------------------------
// ilp_queue
// Short register queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module ilp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ilp_pkg::ilp_cls_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output ilp_pkg::ilp_cls_t pop_data
);
  import ilp_pkg::*;

  ilp_cls_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign avail    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/ilp_back.sv
// ----------------------------------------------------------------------------
// ilp_back
// Literal state machine, accumulator and result register.
// ----------------------------------------------------------------------------
module ilp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              avail,
  input  ilp_pkg::ilp_cls_t cls,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ilp_pkg::ilp_out_t out_data
);
  import ilp_pkg::*;

  typedef enum logic [12:0] {
    PH_START   = 13'b0_0000_0000_0001,
    PH_ZERO    = 13'b0_0000_0000_0010,
    PH_BIN     = 13'b0_0000_0000_0100,
    PH_HEX     = 13'b0_0000_0000_1000,
    PH_OCT     = 13'b0_0000_0001_0000,
    PH_DEC     = 13'b0_0000_0010_0000,
    PH_SFX0    = 13'b0_0000_0100_0000,
    PH_SFX_U   = 13'b0_0000_1000_0000,
    PH_SFX_L   = 13'b0_0001_0000_0000,
    PH_SFX_LL  = 13'b0_0010_0000_0000,
    PH_SFX_Z   = 13'b0_0100_0000_0000,
    PH_SFX_END = 13'b0_1000_0000_0000,
    PH_DEAD    = 13'b1_0000_0000_0000
  } ilp_phase_t;

  ilp_phase_t         phase_r, phase_nxt, sfx_src;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  ilp_radix_t         radix_r, radix_nxt;
  logic               seen_r, seen_nxt;
  logic               lead_r, lead_nxt;
  logic               trail_r, trail_nxt;
  logic               sfx_u_r, sfx_u_nxt;
  logic               sfx_l_r, sfx_l_nxt;
  logic               sfx_ll_r, sfx_ll_nxt;
  logic               sfx_z_r, sfx_z_nxt;
  logic               bad_r, bad_nxt;
  logic               wrap_r, wrap_nxt;
  logic               out_valid_r;
  ilp_out_t           out_data_r;

  logic               run, sfx_go, in_radix;
  logic [VALUE_W+3:0] prod, sum;
  ilp_err_t           err;
  ilp_long_t          lk;

  // stall only a closing character while the result slot is still taken
  assign pop       = avail && (!cls.last || !out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // accumulator * base + digit, widened to catch the wrap
  always_comb begin
    case (radix_r)
      RX_BIN:  prod = {4'b0, acc_r} << 1;
      RX_OCT:  prod = {4'b0, acc_r} << 3;
      RX_HEX:  prod = {4'b0, acc_r} << 4;
      default: prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1);
    endcase
    sum = prod + (VALUE_W + 4)'(cls.dval);

    case (radix_r)
      RX_BIN:  in_radix = cls.dok && (cls.dval < 4'd2);
      RX_OCT:  in_radix = cls.dok && (cls.dval < 4'd8);
      RX_HEX:  in_radix = cls.dok;
      default: in_radix = cls.dok && (cls.dval < 4'd10);
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    radix_nxt  = radix_r;
    seen_nxt   = seen_r;
    lead_nxt   = lead_r;
    trail_nxt  = trail_r;
    sfx_u_nxt  = sfx_u_r;
    sfx_l_nxt  = sfx_l_r;
    sfx_ll_nxt = sfx_ll_r;
    sfx_z_nxt  = sfx_z_r;
    bad_nxt    = bad_r;
    wrap_nxt   = wrap_r;
    run        = 1'b0;
    sfx_go     = 1'b0;
    sfx_src    = phase_r;

    if (pop) begin
      unique case (phase_r) inside
        PH_START: begin
          if (cls.dok && cls.dval == 4'd0) begin
            radix_nxt = RX_OCT;
            acc_nxt   = '0;
            phase_nxt = PH_ZERO;
          end else if (cls.dok && cls.dval < 4'd10) begin
            radix_nxt = RX_DEC;
            acc_nxt   = VALUE_W'(cls.dval);
            phase_nxt = PH_DEC;
          end else begin
            bad_nxt   = 1'b1;
            phase_nxt = PH_DEAD;
          end
        end
        PH_ZERO: begin
          if (cls.is_b) begin
            radix_nxt = RX_BIN;
            phase_nxt = PH_BIN;
          end else if (cls.is_x) begin
            radix_nxt = RX_HEX;
            phase_nxt = PH_HEX;
          end else begin
            phase_nxt = PH_OCT;
            run       = 1'b1;
          end
        end
        PH_BIN, PH_HEX, PH_OCT, PH_DEC: run = 1'b1;
        default: sfx_go = 1'b1;
      endcase

      if (run) begin
        if (cls.sep) begin
          // leading separator only counts right after 0b / 0x
          if (!seen_r && (phase_r == PH_BIN || phase_r == PH_HEX)) begin
            lead_nxt = 1'b1;
          end
          seen_nxt  = 1'b1;
          trail_nxt = 1'b1;
        end else if (in_radix) begin
          seen_nxt  = 1'b1;
          trail_nxt = 1'b0;
          acc_nxt   = sum[VALUE_W-1:0];
          if (sum[VALUE_W+3:VALUE_W] != 4'd0) begin
            wrap_nxt = 1'b1;
          end
        end else begin
          sfx_go  = 1'b1;
          sfx_src = PH_SFX0;
        end
      end

      if (sfx_go) begin
        phase_nxt = PH_DEAD;
        unique case (sfx_src) inside
          PH_SFX0: begin
            if (cls.is_u) begin
              sfx_u_nxt = 1'b1;
              phase_nxt = PH_SFX_U;
            end else if (cls.is_l) begin
              sfx_l_nxt = 1'b1;
              phase_nxt = PH_SFX_L;
            end else if (cls.is_z) begin
              sfx_z_nxt = 1'b1;
              phase_nxt = PH_SFX_Z;
            end
          end
          PH_SFX_U: begin
            if (cls.is_l) begin
              sfx_l_nxt = 1'b1;
              phase_nxt = PH_SFX_L;
            end else if (cls.is_z) begin
              sfx_z_nxt = 1'b1;
              phase_nxt = PH_SFX_Z;
            end
          end
          PH_SFX_L: begin
            if (cls.is_l) begin
              sfx_l_nxt  = 1'b0;
              sfx_ll_nxt = 1'b1;
              phase_nxt  = PH_SFX_LL;
            end else if (cls.is_u) begin
              sfx_u_nxt = 1'b1;
              phase_nxt = PH_SFX_END;
            end
          end
          PH_SFX_LL, PH_SFX_Z: begin
            if (cls.is_u) begin
              sfx_u_nxt = 1'b1;
              phase_nxt = PH_SFX_END;
            end
          end
          default: phase_nxt = PH_DEAD;
        endcase
        if (phase_nxt == PH_DEAD) begin
          bad_nxt = 1'b1;
        end
      end
    end
  end

  // result fields from the post-update state
  always_comb begin
    if (lead_nxt) begin
      err = ERR_LEAD;
    end else if (trail_nxt) begin
      err = ERR_TRAIL;
    end else if (bad_nxt) begin
      err = ERR_BAD;
    end else begin
      err = ERR_OK;
    end
    if (sfx_ll_nxt) begin
      lk = LK_LL;
    end else if (sfx_l_nxt) begin
      lk = LK_L;
    end else begin
      lk = LK_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (pop && cls.last)) begin
      phase_r  <= PH_START;
      acc_r    <= '0;
      radix_r  <= RX_DEC;
      seen_r   <= 1'b0;
      lead_r   <= 1'b0;
      trail_r  <= 1'b0;
      sfx_u_r  <= 1'b0;
      sfx_l_r  <= 1'b0;
      sfx_ll_r <= 1'b0;
      sfx_z_r  <= 1'b0;
      bad_r    <= 1'b0;
      wrap_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      radix_r  <= radix_nxt;
      seen_r   <= seen_nxt;
      lead_r   <= lead_nxt;
      trail_r  <= trail_nxt;
      sfx_u_r  <= sfx_u_nxt;
      sfx_l_r  <= sfx_l_nxt;
      sfx_ll_r <= sfx_ll_nxt;
      sfx_z_r  <= sfx_z_nxt;
      bad_r    <= bad_nxt;
      wrap_r   <= wrap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && cls.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cls.last) begin
      out_data_r.value       <= 64'(acc_nxt);
      out_data_r.radix       <= radix_nxt;
      out_data_r.is_unsigned <= sfx_u_nxt;
      out_data_r.long_kind   <= lk;
      out_data_r.is_size     <= sfx_z_nxt;
      out_data_r.overflowed  <= wrap_nxt;
      out_data_r.error_code  <= err;
    end
  end

endmodule

### rtl/integer_literal_parser.sv
// out_valid rises once the transaction carrying the last character has passed
// a queue slot and then the result register. One character per cycle is
// sustained, the back end taking one queued character each cycle. Only a
// closing character waits, and only while the previous result is still
// untaken. Reset (rst_n low, synchronous) empties the queue, drops out_valid
// and restarts the parser.
// ----------------------------------------------------------------------------
// integer_literal_parser
// Streaming parser for one C++ integer literal, one character per
// transaction, emitting value, radix, suffix flags and error code.
// ----------------------------------------------------------------------------
module integer_literal_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ilp_pkg::ilp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ilp_pkg::ilp_out_t out_data
);
  import ilp_pkg::*;

  // Front end: pure classification of the incoming character (digit value,
  // separator, prefix and suffix letters); it never looks at parser state,
  // so it can accept a transaction whenever the queue has room.
  ilp_cls_t front_cls;
  ilp_cls_t back_cls;
  logic     q_full;
  logic     q_avail;
  logic     q_pop;
  logic     q_push;

  ilp_front u_front (
    .in_item (in_data),
    .cls     (front_cls)
  );

  // in_ready comes straight from the registered queue fill, so no
  // combinational path runs from out_ready back to in_ready.
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Two-entry queue: lets the front keep accepting while the back end
  // holds a closing character behind an untaken result.
  ilp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_cls),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (back_cls)
  );

  // Back end: phase machine, accumulator (value * base + digit with wrap
  // detection from the carry-out bits) and the result register.
  ilp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .avail     (q_avail),
    .cls       (back_cls),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### verif/integer_literal_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_literal_parser_tb
// Self-checking bench for the integer literal parser. Literals are streamed
// one character per transaction. A scoreboard class tracks the parse state of
// every accepted character and checks each result against its own prediction.
// Both handshakes see random idle bursts.
// ----------------------------------------------------------------------------
module integer_literal_parser_tb;
  import ilp_pkg::*;

  localparam int RANDOM_CHARS = 660;
  localparam int CALM_AFTER   = 560;   // no idling past this many random chars
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction at all

  // parser phases, mirroring the block's walk through prefix, digits, suffix
  typedef enum logic [3:0] {
    PH_START, PH_ZERO, PH_BIN, PH_HEX, PH_OCT, PH_DEC,
    PH_SFX0, PH_SFX_U, PH_SFX_L, PH_SFX_LL, PH_SFX_Z, PH_SFX_END, PH_DEAD
  } parse_phase_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the parse of each literal and checks the results.
  // --------------------------------------------------------------------------
  class literal_scoreboard;
    parse_phase_t phase;
    logic [63:0]  acc;
    ilp_radix_t   radix;
    bit           seen_digit, lead_sep, trail_sep, bad_char, wrapped;
    bit           sfx_u, sfx_l, sfx_ll, sfx_z;
    ilp_out_t     expected_q[$];
    int           mismatches, unexpected, reports, checked;
    int           err_seen[4];

    function new();
      clear();
    endfunction

    function void clear();
      phase      = PH_START;
      acc        = '0;
      radix      = RX_DEC;
      seen_digit = 0;
      lead_sep   = 0;
      trail_sep  = 0;
      bad_char   = 0;
      wrapped    = 0;
      sfx_u      = 0;
      sfx_l      = 0;
      sfx_ll     = 0;
      sfx_z      = 0;
    endfunction

    function int digit_value(logic [7:0] c);
      int d;
      d = -1;
      if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
      else if (c >= CH_LA && c <= CH_LF) d = c - HEX_OFS;
      else if (c >= "A" && c <= "F") d = c - "A" + 10;
      if (d < 0) return -1;
      if (radix == RX_BIN && d > 1) return -1;
      if (radix == RX_OCT && d > 7) return -1;
      if (radix == RX_DEC && d > 9) return -1;
      return d;
    endfunction

    // multiply-accumulate with sticky wrap detection
    function void take_digit(int d);
      logic [63:0] m, b, lim;
      m = (VALUE_W >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_W) - 64'd1);
      case (radix)
        RX_BIN:  b = 64'd2;
        RX_OCT:  b = 64'd8;
        RX_HEX:  b = 64'd16;
        default: b = 64'd10;
      endcase
      lim = (m - 64'(d)) / b;
      if (acc > lim) wrapped = 1;
      acc = (acc * b + 64'(d)) & m;
    endfunction

    function void kill();
      bad_char = 1;
      phase    = PH_DEAD;
    endfunction

    function void suffix_char(logic [7:0] c);
      logic [7:0] lc;
      bit         is_u, is_l, is_z;
      lc   = c | CASE_BIT;
      is_u = (lc == CH_LU);
      is_l = (lc == CH_LL);
      is_z = (lc == CH_LZ);
      case (phase)
        PH_SFX0: begin
          if (is_u) begin sfx_u = 1; phase = PH_SFX_U; end
          else if (is_l) begin sfx_l = 1; phase = PH_SFX_L; end
          else if (is_z) begin sfx_z = 1; phase = PH_SFX_Z; end
          else kill();
        end
        PH_SFX_U: begin
          if (is_l) begin sfx_l = 1; phase = PH_SFX_L; end
          else if (is_z) begin sfx_z = 1; phase = PH_SFX_Z; end
          else kill();
        end
        PH_SFX_L: begin
          if (is_l) begin sfx_l = 0; sfx_ll = 1; phase = PH_SFX_LL; end
          else if (is_u) begin sfx_u = 1; phase = PH_SFX_END; end
          else kill();
        end
        PH_SFX_LL, PH_SFX_Z: begin
          if (is_u) begin sfx_u = 1; phase = PH_SFX_END; end
          else kill();
        end
        default: kill();
      endcase
    endfunction

    // one character of the digit run (or the first of the suffix)
    function void run_char(logic [7:0] c);
      int d;
      d = digit_value(c);
      if (c == CH_SEP) begin
        // only a separator straight after 0b / 0x counts as leading
        if (!seen_digit && (phase == PH_BIN || phase == PH_HEX)) lead_sep = 1;
        seen_digit = 1;
        trail_sep  = 1;
      end else if (d >= 0) begin
        seen_digit = 1;
        trail_sep  = 0;
        take_digit(d);
      end else begin
        phase = PH_SFX0;
        suffix_char(c);
      end
    endfunction

    function void note_char(ilp_in_t t);
      ilp_out_t r;
      case (phase)
        PH_START: begin
          if (t.ch == CH_ZERO) begin
            radix = RX_OCT;
            acc   = '0;
            phase = PH_ZERO;
          end else if (t.ch >= "1" && t.ch <= CH_NINE) begin
            radix = RX_DEC;
            acc   = 64'(t.ch - CH_ZERO);
            phase = PH_DEC;
          end else kill();
        end
        PH_ZERO: begin
          if ((t.ch | CASE_BIT) == CH_LB) begin radix = RX_BIN; phase = PH_BIN; end
          else if ((t.ch | CASE_BIT) == CH_LX) begin radix = RX_HEX; phase = PH_HEX; end
          else begin phase = PH_OCT; run_char(t.ch); end
        end
        PH_BIN, PH_HEX, PH_OCT, PH_DEC: run_char(t.ch);
        default: suffix_char(t.ch);
      endcase
      if (t.last) begin
        r.value       = acc;
        r.radix       = radix;
        r.is_unsigned = sfx_u;
        r.long_kind   = sfx_ll ? LK_LL : (sfx_l ? LK_L : LK_NONE);
        r.is_size     = sfx_z;
        r.overflowed  = wrapped;
        r.error_code  = lead_sep ? ERR_LEAD : (trail_sep ? ERR_TRAIL :
                        (bad_char ? ERR_BAD : ERR_OK));
        expected_q.push_back(r);
        clear();
      end
    endfunction

    function void check_result(ilp_out_t got);
      ilp_out_t exp_r;
      if (expected_q.size() == 0) begin
        unexpected++;
        if (reports < 10)
          $display("unexpected result: value=%h radix=%0d err=%0d",
                   got.value, got.radix, got.error_code);
        reports++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      err_seen[exp_r.error_code]++;
      if (got !== exp_r) begin
        mismatches++;
        if (reports < 10) begin
          $display("mismatch: exp value=%h radix=%0d u=%0d long=%0d z=%0d ovf=%0d err=%0d",
                   exp_r.value, exp_r.radix, exp_r.is_unsigned, exp_r.long_kind,
                   exp_r.is_size, exp_r.overflowed, exp_r.error_code);
          $display("          got value=%h radix=%0d u=%0d long=%0d z=%0d ovf=%0d err=%0d",
                   got.value, got.radix, got.is_unsigned, got.long_kind,
                   got.is_size, got.overflowed, got.error_code);
        end
        reports++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int failures();
      return mismatches + unexpected;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ilp_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ilp_out_t out_data;

  literal_scoreboard sb = new();

  logic [7:0] lit[$];      // literal being assembled
  int         chars_sent = 0;
  int         gap_rate   = 0;  // 0: no input gaps for this literal
  bit         calm       = 0;  // set for the closing stretch: no idling at all
  int         quiet_cycles = 0;

  // directed literals: prefixes, lone zero, empty runs, separator corner
  // cases, extremes of the value, several suffix forms and invalid tails
  string directed_lits[$] = '{
    "0", "7", "x", "0b", "0X", "0'7", "0b'1", "0x'", "1''2", "12'u", "08",
    "0b102", "0xFFFFFFFFFFFFFFFF", "18446744073709551616",
    "18446744073709551615uLL", "0B1010lu", "077zU", "1lz", "0x1fLlu",
    "12q3x", "0xaBcDeFull", "5Z", "3uz"
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  integer_literal_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // --------------------------------------------------------------------------
  // Monitor: every handshake on either channel goes to the scoreboard. The
  // input side is handled first so a same-edge result still finds its entry.
  // The watchdog counts edges on which neither channel moves a transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_char(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("integer_literal_parser_tb NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure: random stall bursts between ready stretches,
  // switched off for the closing part of the run.
  // --------------------------------------------------------------------------
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input driving
  // --------------------------------------------------------------------------
  // Presents one character and holds it until accepted; may first drop valid
  // for an idle burst. Called right after the previous acceptance edge, so
  // valid is never lowered and raised in the same step.
  task automatic send_char(logic [7:0] c, logic is_last);
    ilp_in_t t;
    if (!calm && gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    t.ch     = c;
    t.last   = is_last;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  // sends the assembled literal, closing flag on its final character
  task automatic send_lit();
    case ($urandom_range(0, 2))
      0:       gap_rate = 0;
      1:       gap_rate = 4;
      default: gap_rate = 12;
    endcase
    foreach (lit[k]) send_char(lit[k], k == lit.size() - 1);
    lit.delete();
  endtask

  task automatic put_str(string s);
    for (int k = 0; k < s.len(); k++) lit.push_back(s[k]);
  endtask

  task automatic put_digit(int base);
    int d;
    d = $urandom_range(0, base - 1);
    if (d < 10) lit.push_back(CH_ZERO + 8'(d));
    else if ($urandom_range(0, 1)) lit.push_back(CH_LA + 8'(d - 10));
    else lit.push_back(8'("A") + 8'(d - 10));
  endtask

  // suffix letters in random case, u/l/z only
  task automatic put_suffix(string s);
    logic [7:0] c;
    for (int k = 0; k < s.len(); k++) begin
      c = s[k];
      if ($urandom_range(0, 1)) c = c & ~CASE_BIT;
      lit.push_back(c);
    end
  endtask

  // prefix, digit run with separators now and then, optional legal suffix
  task automatic put_wellformed();
    ilp_radix_t rx;
    int         base, ndig;
    string      sfx_list[$] = '{"", "", "", "u", "l", "ll", "ul", "ull", "lu", "llu",
                                "z", "zu", "uz"};
    rx = ilp_radix_t'($urandom_range(0, 3));
    case (rx)
      RX_DEC: begin
        lit.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
        base = 10;
      end
      RX_BIN: begin
        put_str($urandom_range(0, 1) ? "0b" : "0B");
        base = 2;
      end
      RX_OCT: begin
        put_str("0");
        base = 8;
      end
      default: begin
        put_str($urandom_range(0, 1) ? "0x" : "0X");
        base = 16;
      end
    endcase
    // mostly short runs; now and then one long enough that it may wrap
    if ($urandom_range(0, 7) == 0) begin
      case (rx)
        RX_DEC:  ndig = $urandom_range(18, 21);
        RX_BIN:  ndig = $urandom_range(62, 66);
        RX_OCT:  ndig = $urandom_range(21, 23);
        default: ndig = $urandom_range(15, 17);
      endcase
    end else ndig = $urandom_range(0, 6);
    if ($urandom_range(0, 11) == 0) lit.push_back(CH_SEP);
    for (int k = 0; k < ndig; k++) begin
      put_digit(base);
      if ($urandom_range(0, 6) == 0) lit.push_back(CH_SEP);
    end
    put_suffix(sfx_list[$urandom_range(0, sfx_list.size() - 1)]);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int random_start;
    int pos;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_lits[k]) begin
      put_str(directed_lits[k]);
      send_lit();
    end
    // characters with the top bit set, mid-literal and as a lone closer
    put_str("1");
    lit.push_back(8'hA7);
    send_lit();
    lit.push_back(8'hFF);
    send_lit();

    // random part: three quarters well-formed literals, the rest noise
    random_start = chars_sent;
    while (chars_sent - random_start < RANDOM_CHARS) begin
      if (chars_sent - random_start >= CALM_AFTER) calm = 1;
      case ($urandom_range(0, 11))
        0: begin
          repeat ($urandom_range(1, 6)) lit.push_back(8'($urandom_range(0, 255)));
        end
        1: begin
          put_wellformed();
          pos = $urandom_range(0, lit.size() - 1);
          lit[pos] = 8'($urandom_range(0, 255));
        end
        2: begin
          put_wellformed();
          put_suffix($urandom_range(0, 1) ? "lz" : "uu");
        end
        default: put_wellformed();
      endcase
      send_lit();
    end
    in_valid <= 1'b0;

    // drain, then allow for the pipeline before declaring the verdict
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d characters sent, %0d literals checked (%0d mismatches, %0d unexpected)",
             chars_sent, sb.checked, sb.mismatches, sb.unexpected);
    $display("error codes seen: ok %0d, leading sep %0d, trailing sep %0d, invalid %0d",
             sb.err_seen[ERR_OK], sb.err_seen[ERR_LEAD], sb.err_seen[ERR_TRAIL],
             sb.err_seen[ERR_BAD]);
    if (sb.failures() == 0 && sb.pending() == 0) begin
      $display("integer_literal_parser_tb OK");
    end else begin
      $display("integer_literal_parser_tb NOT OK");
    end
    $finish;
  end

endmodule
